@@ rtl/ssr_pkg.sv @@
// ---------------------------------------------------------------------------
// ssr_pkg: shared definitions for the sphere scissor rectangle block
// Field widths, register codes, pipeline depths and reset values.
// ---------------------------------------------------------------------------
package ssr_pkg;

  localparam int CENTER_W   = 32;
  localparam int RADIUS_W   = 31;
  localparam int NEAR_W     = 31;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // normalized edge, signed Q2.16 in [-2, 2]
  localparam int EDGE_W = 19;
  localparam logic signed [EDGE_W-1:0] EDGE_ONE     = 19'sd65536;
  localparam logic signed [EDGE_W-1:0] EDGE_NEG_ONE = -19'sd65536;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 18;
  localparam int AXIS_LAT   = 11 + SQRT_STEPS + DIV_STEPS;

  localparam logic [NEAR_W-1:0] NEAR_RST     = 31'd65536;
  localparam logic [NEAR_W-1:0] HALF_RST     = 31'd65536;
  localparam logic [PIX_W-1:0]  SCREEN_W_RST = 16'd1920;
  localparam logic [PIX_W-1:0]  SCREEN_H_RST = 16'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR     = 3'd0,
    CFG_HALF_W   = 3'd1,
    CFG_HALF_H   = 3'd2,
    CFG_SCREEN_W = 3'd3,
    CFG_SCREEN_H = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [NEAR_W-1:0] near_dist;
    logic [NEAR_W-1:0] half_size;
  } axis_cfg_t;

endpackage

@@ rtl/ssr_axis.sv @@
// ---------------------------------------------------------------------------
// ssr_axis: tangent-plane edge solver for one screen axis
// Squares, pipelined integer square root, root terms, pipelined restoring
// divide per root, and the low/high edge pick. Advances when en_i is high.
// ---------------------------------------------------------------------------
module ssr_axis (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [ssr_pkg::CENTER_W-1:0]     c_i,
  input  logic signed [ssr_pkg::CENTER_W-1:0]     z_i,
  input  logic        [ssr_pkg::RADIUS_W-1:0]     r_i,
  input  ssr_pkg::axis_cfg_t                      cfg_i,
  output logic signed [ssr_pkg::EDGE_W-1:0]       low_o,
  output logic signed [ssr_pkg::EDGE_W-1:0]       high_o
);
  import ssr_pkg::*;

  typedef struct packed {
    logic signed [31:0] c;
    logic [31:0]        zmag;
    logic               zneg;
    logic               ok;
    logic signed [46:0] rc16;
    logic [45:0]        rz16;
  } sq_side_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic eneg;
  } root_t;

  // ---- stage 1: capture
  logic signed [31:0] c0_q, z0_q;
  logic [31:0]        zmag0_q;
  logic [30:0]        r0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q    <= c_i;
      z0_q    <= z_i;
      zmag0_q <= z_i[31] ? 32'(-z_i) : 32'(z_i);
      r0_q    <= r_i;
    end
  end

  // ---- stage 2: products
  logic [63:0]        cc1_q, zz1_q;
  logic [61:0]        rr1_q, rz1_q;
  logic signed [62:0] rc1_q;
  logic signed [31:0] c1_q;
  logic [31:0]        zmag1_q;
  logic               zneg1_q, znz1_q, rnz1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc1_q   <= c0_q * c0_q;
      zz1_q   <= z0_q * z0_q;
      rr1_q   <= r0_q * r0_q;
      rz1_q   <= r0_q * zmag0_q;
      rc1_q   <= $signed({1'b0, r0_q}) * c0_q;
      c1_q    <= c0_q;
      zmag1_q <= zmag0_q;
      zneg1_q <= z0_q[31];
      znz1_q  <= |z0_q;
      rnz1_q  <= |r0_q;
    end
  end

  // ---- stage 3: squared distance
  logic [63:0]        len2_q;
  logic [61:0]        rr2_q;
  logic signed [46:0] rc16_2_q;
  logic [45:0]        rz16_2_q;
  logic signed [31:0] c2_q;
  logic [31:0]        zmag2_q;
  logic               zneg2_q, use2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len2_q   <= cc1_q + zz1_q;
      rr2_q    <= rr1_q;
      rc16_2_q <= rc1_q[62:16];
      rz16_2_q <= rz1_q[61:16];
      c2_q     <= c1_q;
      zmag2_q  <= zmag1_q;
      zneg2_q  <= zneg1_q;
      use2_q   <= znz1_q & rnz1_q;
    end
  end

  // ---- stage 4: discriminant, then square root stages
  logic [64:0]  disc;
  logic [63:0]  sq_v_q   [SQRT_STEPS+1];
  logic [63:0]  sq_res_q [SQRT_STEPS+1];
  sq_side_t     sq_side_q[SQRT_STEPS+1];

  assign disc = {1'b0, len2_q} - {3'b000, rr2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_v_q[0]         <= disc[63:0];
      sq_res_q[0]       <= '0;
      sq_side_q[0].c    <= c2_q;
      sq_side_q[0].zmag <= zmag2_q;
      sq_side_q[0].zneg <= zneg2_q;
      sq_side_q[0].ok   <= use2_q & ~disc[64] & (|disc[63:0]);
      sq_side_q[0].rc16 <= rc16_2_q;
      sq_side_q[0].rz16 <= rz16_2_q;
    end
  end

  for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (SQRT_STEPS - i));
    logic [63:0] trial;
    logic        ge;

    assign trial = sq_res_q[i-1] + SQ_BIT;
    assign ge    = sq_v_q[i-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_v_q[i]    <= ge ? sq_v_q[i-1] - trial : sq_v_q[i-1];
        sq_res_q[i]  <= ge ? (sq_res_q[i-1] >> 1) + SQ_BIT : sq_res_q[i-1] >> 1;
        sq_side_q[i] <= sq_side_q[i-1];
      end
    end
  end

  // ---- root products with the square root
  logic [31:0]        s_root;
  logic [63:0]        zs_q;
  logic signed [63:0] cs_q;
  logic signed [46:0] rc16_m_q;
  logic [45:0]        rz16_m_q;
  logic               zneg_m_q, ok_m_q;

  assign s_root = sq_res_q[SQRT_STEPS][31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zs_q     <= sq_side_q[SQRT_STEPS].zmag * s_root;
      cs_q     <= sq_side_q[SQRT_STEPS].c * $signed({1'b0, s_root});
      rc16_m_q <= sq_side_q[SQRT_STEPS].rc16;
      rz16_m_q <= sq_side_q[SQRT_STEPS].rz16;
      zneg_m_q <= sq_side_q[SQRT_STEPS].zneg;
      ok_m_q   <= sq_side_q[SQRT_STEPS].ok;
    end
  end

  // ---- normal (a) and depth (b) terms; index 0 is the plus root
  logic signed [48:0] rc49, zs49, cs49, rz49;
  logic signed [48:0] a_q[2], b_q[2];
  logic               zneg_ab_q, ok_ab_q;

  assign rc49 = {{2{rc16_m_q[46]}}, rc16_m_q};
  assign zs49 = {2'b00, zs_q[62:16]};
  assign cs49 = {cs_q[63], cs_q[63:16]};
  assign rz49 = {3'b000, rz16_m_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]    <= rc49 + zs49;
      a_q[1]    <= rc49 - zs49;
      b_q[0]    <= rz49 - cs49;
      b_q[1]    <= rz49 + cs49;
      zneg_ab_q <= zneg_m_q;
      ok_ab_q   <= ok_m_q;
    end
  end

  // ---- per root: magnitudes, root checks, divide
  logic signed [EDGE_W-1:0] e_q [2];
  root_t                    ef_q[2];

  for (genvar j = 0; j < 2; j++) begin : g_root
    logic               aneg, bneg, rvalid;
    logic [48:0]        aabs, babs;
    logic [47:0]        amag_q, bmag_q;
    root_t              rt_q, prt_q;
    logic [54:0]        pbl_q, pbh_q, pal_q, pah_q;
    logic [78:0]        xsum, ysum;
    logic [95:0]        dx_q [DIV_STEPS+1];
    logic [78:0]        dy_q [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dq_q [DIV_STEPS+1];
    logic               dxz_q[DIV_STEPS+1];
    root_t              drt_q[DIV_STEPS+1];
    logic [17:0]        mag;

    assign aneg   = a_q[j][48];
    assign bneg   = b_q[j][48];
    assign aabs   = aneg ? -a_q[j] : a_q[j];
    assign babs   = bneg ? -b_q[j] : b_q[j];
    // root is kept only when its tangency point is in front of the camera
    assign rvalid = ok_ab_q & (|a_q[j]) & ((j == 1) ^ zneg_ab_q ^ aneg);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        amag_q  <= aabs[47:0];
        bmag_q  <= babs[47:0];
        rt_q.lo   <= rvalid & ~aneg;
        rt_q.hi   <= rvalid & aneg;
        rt_q.eneg <= zneg_ab_q ^ aneg ^ bneg;
      end
    end

    // split 48-bit magnitudes into two halves per multiply
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pbl_q <= bmag_q[23:0]  * cfg_i.near_dist;
        pbh_q <= bmag_q[47:24] * cfg_i.near_dist;
        pal_q <= amag_q[23:0]  * cfg_i.half_size;
        pah_q <= amag_q[47:24] * cfg_i.half_size;
        prt_q <= rt_q;
      end
    end

    assign xsum = {pbh_q, 24'd0} + {24'd0, pbl_q};
    assign ysum = {pah_q, 24'd0} + {24'd0, pal_q};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dx_q[0]  <= {1'b0, xsum, 16'd0};
        dy_q[0]  <= ysum;
        dq_q[0]  <= '0;
        dxz_q[0] <= ~|xsum;
        drt_q[0] <= prt_q;
      end
    end

    // first step (top quotient bit) flags saturation
    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      localparam int K = DIV_STEPS - s;
      logic [96:0] yk;
      logic        ge;

      assign yk = {18'd0, dy_q[s-1]} << K;
      assign ge = {1'b0, dx_q[s-1]} >= yk;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dx_q[s]  <= ge ? dx_q[s-1] - yk[95:0] : dx_q[s-1];
          dy_q[s]  <= dy_q[s-1];
          dq_q[s]  <= dq_q[s-1] | (ge ? DIV_STEPS'(1) << K : '0);
          dxz_q[s] <= dxz_q[s-1];
          drt_q[s] <= drt_q[s-1];
        end
      end
    end

    always_comb begin
      if (dxz_q[DIV_STEPS]) begin
        mag = '0;
      end else if (dq_q[DIV_STEPS][DIV_STEPS-1]) begin
        mag = 18'd131072;
      end else begin
        mag = {1'b0, dq_q[DIV_STEPS][16:0]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[j]  <= drt_q[DIV_STEPS].eneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        ef_q[j] <= drt_q[DIV_STEPS];
      end
    end
  end

  // ---- narrow [-1, 1] by the kept roots
  logic signed [EDGE_W-1:0] lo_d, hi_d, low_q, high_q;

  always_comb begin
    lo_d = EDGE_NEG_ONE;
    hi_d = EDGE_ONE;
    if (ef_q[0].lo && e_q[0] > lo_d) lo_d = e_q[0];
    if (ef_q[1].lo && e_q[1] > lo_d) lo_d = e_q[1];
    if (ef_q[0].hi && e_q[0] < hi_d) hi_d = e_q[0];
    if (ef_q[1].hi && e_q[1] < hi_d) hi_d = e_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      low_q  <= lo_d;
      high_q <= hi_d;
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

@@ rtl/sphere_screen_scissor_rect_top.sv @@
// ---------------------------------------------------------------------------
// sphere_screen_scissor_rect_top: light sphere to screen scissor rectangle
// Per axis edge solve, scale to pixels, clamp to the window, report
// left/bottom corner and size.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid_i/in_stall_o  | center_x/y/z_i, sphere_radius_i
//  output   | out_valid_o/out_stall_i| rect_x/y_o, rect_width/height_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One transaction enters per cycle while in_stall_o is low; the latency is
//  set by the 32-step square root and the 18-step divider stages.
//  Reset clears the valid bits and loads the register defaults.
//  A held result at the output freezes the whole pipeline; nothing is
//  dropped or repeated. Config writes are always ready.
// ---------------------------------------------------------------------------
module sphere_screen_scissor_rect_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ssr_pkg::CENTER_W-1:0]   center_x_i,
  input  logic signed [ssr_pkg::CENTER_W-1:0]   center_y_i,
  input  logic signed [ssr_pkg::CENTER_W-1:0]   center_z_i,
  input  logic        [ssr_pkg::RADIUS_W-1:0]   sphere_radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [ssr_pkg::PIX_W-1:0]      rect_x_o,
  output logic        [ssr_pkg::PIX_W-1:0]      rect_y_o,
  output logic        [ssr_pkg::PIX_W-1:0]      rect_width_o,
  output logic        [ssr_pkg::PIX_W-1:0]      rect_height_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [ssr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [ssr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ssr_pkg::*;

  localparam int VLD_N = AXIS_LAT + 3;

  // ---- configuration registers
  logic [NEAR_W-1:0] near_q, half_w_q, half_h_q;
  logic [PIX_W-1:0]  scr_w_q, scr_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= NEAR_RST;
      half_w_q <= HALF_RST;
      half_h_q <= HALF_RST;
      scr_w_q  <= SCREEN_W_RST;
      scr_h_q  <= SCREEN_H_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NEAR:     near_q   <= cfg_data_i[NEAR_W-1:0];
        CFG_HALF_W:   half_w_q <= cfg_data_i[NEAR_W-1:0];
        CFG_HALF_H:   half_h_q <= cfg_data_i[NEAR_W-1:0];
        CFG_SCREEN_W: scr_w_q  <= cfg_data_i[PIX_W-1:0];
        CFG_SCREEN_H: scr_h_q  <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control
  logic             en;
  logic [VLD_N-1:0] vld_q;
  logic             out_valid_q;

  assign en         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[VLD_N-2:0], in_valid_i};
      out_valid_q <= vld_q[VLD_N-1];
    end
  end

  // ---- axis solvers: index 0 is x, 1 is y
  axis_cfg_t                cfg_ax[2];
  logic signed [EDGE_W-1:0] lo_e[2], hi_e[2];
  logic [PIX_W-1:0]         size_ax[2];

  assign cfg_ax[0]  = '{near_dist: near_q, half_size: half_w_q};
  assign cfg_ax[1]  = '{near_dist: near_q, half_size: half_h_q};
  assign size_ax[0] = scr_w_q;
  assign size_ax[1] = scr_h_q;

  ssr_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .c_i    (center_x_i),
    .z_i    (center_z_i),
    .r_i    (sphere_radius_i),
    .cfg_i  (cfg_ax[0]),
    .low_o  (lo_e[0]),
    .high_o (hi_e[0])
  );

  ssr_axis u_axis_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .c_i    (center_y_i),
    .z_i    (center_z_i),
    .r_i    (sphere_radius_i),
    .cfg_i  (cfg_ax[1]),
    .low_o  (lo_e[1]),
    .high_o (hi_e[1])
  );

  // ---- edge to pixel: offset, scale, clamp
  logic [PIX_W-1:0] pix_lo_q[2], pix_hi_q[2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_pix
    logic signed [EDGE_W-1:0] u_lo_q, u_hi_q;
    logic signed [35:0]       v_lo_q, v_hi_q;
    logic [16:0]              p_lo, p_hi;

    always_ff @(posedge clk_i) begin
      if (en) begin
        u_lo_q <= lo_e[ax] + EDGE_ONE;
        u_hi_q <= hi_e[ax] + EDGE_ONE;
        v_lo_q <= u_lo_q * $signed({1'b0, size_ax[ax]});
        v_hi_q <= u_hi_q * $signed({1'b0, size_ax[ax]});
      end
    end

    assign p_lo = (v_lo_q <= 0) ? 17'd0 : v_lo_q[33:17];
    assign p_hi = (v_hi_q <= 0) ? 17'd0 : v_hi_q[33:17];

    always_ff @(posedge clk_i) begin
      if (en) begin
        pix_lo_q[ax] <= (p_lo > {1'b0, size_ax[ax]}) ? size_ax[ax] : p_lo[PIX_W-1:0];
        pix_hi_q[ax] <= (p_hi > {1'b0, size_ax[ax]}) ? size_ax[ax] : p_hi[PIX_W-1:0];
      end
    end
  end

  // ---- output register
  logic [PIX_W-1:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rect_x_q <= pix_lo_q[0];
      rect_y_q <= pix_lo_q[1];
      rect_w_q <= (pix_hi_q[0] > pix_lo_q[0]) ? pix_hi_q[0] - pix_lo_q[0] : '0;
      rect_h_q <= (pix_hi_q[1] > pix_lo_q[1]) ? pix_hi_q[1] - pix_lo_q[1] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_x_o      = rect_x_q;
  assign rect_y_o      = rect_y_q;
  assign rect_width_o  = rect_w_q;
  assign rect_height_o = rect_h_q;

  // ---- assertions
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[VLD_N-1]))
    else $error("result appeared without a transaction in the last stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !vld_q[VLD_N-1] |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule
